// ----- hw/rtl/fibonacci_mod_prime_assert.svh -----
// Assertion macros for the Fibonacci modulo prime block.
`ifndef FIBONACCI_MOD_PRIME_ASSERT_SVH
`define FIBONACCI_MOD_PRIME_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define FMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fibonacci_mod_prime: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define FMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fibonacci_mod_prime: assertion failed");
`else
`define FMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/fmp_pkg.sv -----
// Shared constants, types and the modular reduction helper.
package fmp_pkg;

    localparam int unsigned VAL_W  = 30;
    localparam int unsigned IDX_W  = 63;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned STEP_W = 5;

    localparam logic [VAL_W-1:0] FMP_P   = 30'd1000000007;
    localparam logic [SUM_W-1:0] FMP_P_W = 32'd1000000007;
    localparam logic [SUM_W-1:0] FMP_2P  = 32'd2000000014;

    localparam logic [CNT_W-1:0]  TOP_BIT   = 6'd62;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DONE
    } state_t;

    // Which product the serial multiplier is forming.
    typedef enum logic [1:0] {
        PH_CROSS,   // F(n) * (2F(n+1) - F(n))
        PH_ASQ,     // F(n)^2
        PH_BSQ      // F(n+1)^2
    } phase_t;

    // Reduce a value below 3p into 0..p-1.
    function automatic logic [VAL_W-1:0] red3(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] r;
        if (x >= FMP_2P) begin
            r = x - FMP_2P;
        end else if (x >= FMP_P_W) begin
            r = x - FMP_P_W;
        end else begin
            r = x;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/fibonacci_mod_prime.sv -----
// Fibonacci number modulo 1000000007 by fast doubling on a bit-serial modular multiplier.
//
//  channel | dir | tdata fields (low bit up)          | beat
//  s_      | in  | index[62:0], pad bit 63             | one index k
//  m_      | out | fib_value[29:0], pad bits 31:30     | F(k) mod p
//
// Steps: the beat is taken in idle, then the index is scanned from bit 62 down. A bit
// before the first set bit is only shifted out; the first set bit and each one after it
// cost three 30-step products on the one shift-add multiplier. The done state then
// loads the result.
// Reset (aresetn low, synchronous) clears the sequencer and the result valid.
// s_tready is high only in idle; a result waiting on m_tready holds the
// sequencer in its done state until the output register is free.
module fibonacci_mod_prime (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] index, [63] zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] fib_value, [31:30] zero pad
);

    `include "fibonacci_mod_prime_assert.svh"

    localparam int unsigned VW = fmp_pkg::VAL_W;

    fmp_pkg::state_t state_reg, state_next;
    fmp_pkg::phase_t phase_reg, phase_next;

    // Index shifts left one bit per doubling step; bit 62 is the current one.
    logic [fmp_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [fmp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       started_reg, started_next;
    // (a, b) = (F(n), F(n+1)) for the prefix of k scanned so far.
    logic [VW-1:0]              a_reg, a_next;
    logic [VW-1:0]              b_reg, b_next;
    // Serial multiplier: multiplicand, multiplier shifting out MSB first, partial.
    logic [VW-1:0]              mcand_reg, mcand_next;
    logic [VW-1:0]              mplier_reg, mplier_next;
    logic [VW-1:0]              prod_reg, prod_next;
    logic [fmp_pkg::STEP_W-1:0] step_reg, step_next;
    logic [VW-1:0]              t1_reg, t1_next;
    logic [VW-1:0]              t2_reg, t2_next;
    logic                       mv_reg, mv_next;
    logic [VW-1:0]              md_reg, md_next;

    // Sequencer outputs
    logic in_take, skip_bit, mul_start, mul_step, out_load;
    logic step_last, bit_done, last_bit, cur_bit;

    // Datapath intermediates
    logic [VW-1:0] dbl_diff, prod_new, d_val, bd_val;

    assign cur_bit   = k_reg[fmp_pkg::IDX_W-1];
    assign last_bit  = (cnt_reg == '0);
    assign step_last = (step_reg == fmp_pkg::LAST_STEP);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fmp_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = fmp_pkg::ST_SCAN;
            end
            fmp_pkg::ST_SCAN: begin
                if (cur_bit || started_reg) begin
                    state_next = fmp_pkg::ST_MUL;
                end else if (last_bit) begin
                    state_next = fmp_pkg::ST_DONE;
                end
            end
            fmp_pkg::ST_MUL: begin
                if (step_last && phase_reg == fmp_pkg::PH_BSQ) begin
                    state_next = last_bit ? fmp_pkg::ST_DONE : fmp_pkg::ST_SCAN;
                end
            end
            fmp_pkg::ST_DONE: begin
                if (!mv_reg || m_tready) state_next = fmp_pkg::ST_IDLE;
            end
            default: state_next = fmp_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_tready  = 1'b0;
        skip_bit  = 1'b0;
        mul_start = 1'b0;
        mul_step  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            fmp_pkg::ST_IDLE: s_tready = 1'b1;
            fmp_pkg::ST_SCAN: begin
                mul_start = cur_bit || started_reg;
                skip_bit  = !(cur_bit || started_reg);
            end
            fmp_pkg::ST_MUL:  mul_step = 1'b1;
            fmp_pkg::ST_DONE: out_load = !mv_reg || m_tready;
            default: ;
        endcase
    end

    assign in_take  = s_tready && s_tvalid;
    assign bit_done = mul_step && step_last && (phase_reg == fmp_pkg::PH_BSQ);

    // ---------------- datapath ----------------
    // 2b - a mod p, formed as 2b + p - a which lies below 3p.
    assign dbl_diff = fmp_pkg::red3({1'b0, b_reg, 1'b0} + fmp_pkg::FMP_P_W
                                    - {2'b00, a_reg});
    // One Horner step: 2*prod + bit*mcand, below 3p.
    assign prod_new = fmp_pkg::red3({1'b0, prod_reg, 1'b0}
                                    + (mplier_reg[VW-1] ? {2'b00, mcand_reg} : '0));
    // F(2n+1) = a^2 + b^2; F(2n+2) = F(2n) + F(2n+1).
    assign d_val    = fmp_pkg::red3({2'b00, t2_reg} + {2'b00, prod_new});
    assign bd_val   = fmp_pkg::red3({2'b00, t1_reg} + {2'b00, d_val});

    always_comb begin
        phase_next   = phase_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        prod_next    = prod_reg;
        step_next    = step_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        mv_next      = mv_reg;
        md_next      = md_reg;

        if (in_take) begin
            k_next       = s_tdata[fmp_pkg::IDX_W-1:0];
            cnt_next     = fmp_pkg::TOP_BIT;
            started_next = 1'b0;
            a_next       = '0;
            b_next       = {{(VW-1){1'b0}}, 1'b1};
        end

        // Leading zeros leave (F(0), F(1)) unchanged.
        if (skip_bit) begin
            k_next   = {k_reg[fmp_pkg::IDX_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end

        if (mul_start) begin
            started_next = 1'b1;
            phase_next   = fmp_pkg::PH_CROSS;
            mcand_next   = a_reg;
            mplier_next  = dbl_diff;
            prod_next    = '0;
            step_next    = '0;
        end

        if (mul_step) begin
            prod_next   = prod_new;
            mplier_next = {mplier_reg[VW-2:0], 1'b0};
            step_next   = step_reg + 1'b1;
            if (step_last) begin
                prod_next = '0;
                step_next = '0;
                case (phase_reg)
                    fmp_pkg::PH_CROSS: begin
                        t1_next     = prod_new;
                        phase_next  = fmp_pkg::PH_ASQ;
                        mcand_next  = a_reg;
                        mplier_next = a_reg;
                    end
                    fmp_pkg::PH_ASQ: begin
                        t2_next     = prod_new;
                        phase_next  = fmp_pkg::PH_BSQ;
                        mcand_next  = b_reg;
                        mplier_next = b_reg;
                    end
                    fmp_pkg::PH_BSQ: begin
                        // t1 = F(2n), d = F(2n+1)
                        if (cur_bit) begin
                            a_next = d_val;
                            b_next = bd_val;
                        end else begin
                            a_next = t1_reg;
                            b_next = d_val;
                        end
                        k_next   = {k_reg[fmp_pkg::IDX_W-2:0], 1'b0};
                        cnt_next = cnt_reg - 1'b1;
                    end
                    default: phase_next = fmp_pkg::PH_CROSS;
                endcase
            end
        end

        if (out_load) begin
            mv_next = 1'b1;
            md_next = a_reg;
        end else if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fmp_pkg::ST_IDLE;
            phase_reg   <= fmp_pkg::PH_CROSS;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            step_reg    <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            mv_reg      <= mv_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        md_reg     <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, md_reg};

    // ---------------- assertions ----------------
    `FMP_ASSERT_NOW(a_prod_reduced, aclk, aresetn, state_reg == fmp_pkg::ST_MUL, prod_reg < fmp_pkg::FMP_P)
    `FMP_ASSERT_NOW(a_pair_reduced, aclk, aresetn, state_reg == fmp_pkg::ST_SCAN, (a_reg < fmp_pkg::FMP_P) && (b_reg < fmp_pkg::FMP_P))
    `FMP_ASSERT_NEXT(a_bit_advances, aclk, aresetn, bit_done && !last_bit, state_reg == fmp_pkg::ST_SCAN && cnt_reg == $past(cnt_reg) - 1'b1)
    `FMP_ASSERT_NOW(a_result_from_done, aclk, aresetn, $rose(m_tvalid), $past(state_reg) == fmp_pkg::ST_DONE)

endmodule

// ----- verif/fibonacci_mod_prime_tb.sv -----
// Self-checking testbench for the Fibonacci modulo 1000000007 block.
module fibonacci_mod_prime_tb;

    localparam int unsigned VAL_W = fmp_pkg::VAL_W;
    localparam int unsigned IDX_W = fmp_pkg::IDX_W;

    localparam longint unsigned PRIME = 64'd1000000007;
    localparam int unsigned RANDOM_ITEMS = 750;
    // Drain window: long enough for the longest single item to finish.
    localparam int unsigned DRAIN_CYCLES = 6000;
    localparam int unsigned HOLD_CYCLES = 12000;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [62:0] index, [63] pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [29:0] fib_value, [31:30] pad

    int unsigned recv_idle_pct = 57;
    logic        hold_request = 1'b0;

    fibonacci_mod_prime dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicts F(k) mod p and keeps the values still owed by the block.
    class fib_scoreboard;
        typedef struct {
            longint unsigned e00, e01, e10, e11;
        } fib_mat_t;

        logic [VAL_W-1:0] owed_fib[$];
        int unsigned      errors = 0;

        function fib_mat_t mat_product(fib_mat_t x, fib_mat_t y);
            fib_mat_t r;
            r.e00 = (x.e00 * y.e00 + x.e01 * y.e10) % PRIME;
            r.e01 = (x.e00 * y.e01 + x.e01 * y.e11) % PRIME;
            r.e10 = (x.e10 * y.e00 + x.e11 * y.e10) % PRIME;
            r.e11 = (x.e10 * y.e01 + x.e11 * y.e11) % PRIME;
            return r;
        endfunction

        // Square-and-multiply on [[1,1],[1,0]], exponent k-1, top bit first.
        function logic [VAL_W-1:0] fib_mod_p(logic [IDX_W-1:0] k);
            fib_mat_t         q;
            fib_mat_t         acc;
            logic [IDX_W-1:0] e;
            int               top;
            if (k <= 1) begin
                return VAL_W'(k);
            end
            q = '{1, 1, 1, 0};
            e = k - IDX_W'(1);
            top = IDX_W - 1;
            while (top > 0 && !e[top]) begin
                top--;
            end
            acc = q;
            for (int i = top - 1; i >= 0; i--) begin
                acc = mat_product(acc, acc);
                if (e[i]) begin
                    acc = mat_product(acc, q);
                end
            end
            return acc.e00[VAL_W-1:0];
        endfunction

        function void note_index(logic [IDX_W-1:0] k);
            owed_fib = {owed_fib, fib_mod_p(k)};
        endfunction

        function void check_fib(logic [VAL_W-1:0] got);
            logic [VAL_W-1:0] want;
            if (owed_fib.size() == 0) begin
                $error("fib_value: no beat expected, actual %0d", got);
                errors++;
            end else begin
                want = owed_fib.pop_front();
                if (want !== got) begin
                    $error("fib_value: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    fib_scoreboard fib_sb = new();

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #80000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Random index word: mostly short indices to keep the run short, a few
    // full-width ones. The pad bit is random, the block must ignore it.
    function automatic logic [63:0] random_index_word();
        logic [63:0] w;
        int unsigned pick;
        int unsigned nbits;
        w = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 3) begin
            return w;
        end else if (pick < 8) begin
            w[IDX_W-1:0] = IDX_W'($urandom_range(3));
        end else begin
            nbits = $urandom_range(1, 10);
            w[IDX_W-1:0] = w[IDX_W-1:0] & ((IDX_W'(1) << nbits) - IDX_W'(1));
        end
        return w;
    endfunction

    task automatic idle_sender(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic send_index(input logic [63:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        fib_sb.note_index(word[IDX_W-1:0]);
    endtask

    // Result side: random back-pressure plus one long hold-off.
    initial begin : result_sink
        int unsigned held;
        logic        hold_done;
        held = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                fib_sb.check_fib(m_tdata[VAL_W-1:0]);
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                held = HOLD_CYCLES;
            end
            if (held != 0) begin
                held--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        logic [63:0] directed[$];
        int unsigned send_pct;
        int unsigned drain;

        // Zero and one, the first few small indices, F(p+1) which is zero
        // mod p, the largest index, single and alternating bit patterns, and
        // words with the pad bit set.
        directed = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd12, 64'd45, 64'd46,
            64'd1000000008, 64'd2000000016,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
            64'h4000_0000_0000_0001, 64'h0000_0001_0000_0000,
            64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA,
            64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: sender idles 25 %, receiver 57 %.
        send_pct = 25;
        foreach (directed[i]) begin
            idle_sender(send_pct);
            send_index(directed[i]);
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 20) begin
                hold_request <= 1'b1;
            end else if (n == RANDOM_ITEMS / 3) begin
                send_pct = 57;
                recv_idle_pct <= 25;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_pct = 0;
                recv_idle_pct <= 0;
            end
            idle_sender(send_pct);
            send_index(random_index_word());
        end
        s_tvalid <= 1'b0;

        while (fib_sb.owed_fib.size() != 0) begin
            @(posedge aclk);
        end
        // Catch any stray beat after the last expected one.
        drain = DRAIN_CYCLES;
        while (drain != 0) begin
            @(posedge aclk);
            drain--;
        end

        if (fib_sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fmp_pkg.sv
hw/rtl/fibonacci_mod_prime.sv
verif/fibonacci_mod_prime_tb.sv
